>>> design/r10u_pkg.sv
// Shared types and constants for the raw10 unpack stream block.
// No dependencies; every other design file imports this package.
package r10u_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_PIXEL_MODE = 1'b0;
  localparam logic REG_PAYLOAD_BYTES = 1'b1;

  // Widths fixed by the item formats.
  localparam int MODE_W = 2;
  localparam int PAYLOAD_W = 33;
  localparam int SENT_W = 34;
  localparam int CFG_DATA_W = 33;
  localparam int GROUP_W = 40;

  // Pixel mode codes; any code other than the packed mode passes bytes through.
  localparam logic [MODE_W-1:0] MODE_RAW8 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RAW10 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RAW16 = 2'd2;

  // Input action codes.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Kind of work handed from the front to the back.
  typedef enum logic {
    KIND_PASS,
    KIND_GROUP
  } kind_t;

  // One input word.
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       payload_done;
  } out_item_t;

  // Work entry: a passthrough byte in the low bits, or a whole packed group,
  // plus the sent count that includes the entry's first output byte.
  typedef struct packed {
    kind_t               kind;
    logic [GROUP_W-1:0]  data;
    logic [SENT_W-1:0]   cnt;
  } entry_t;

endpackage

>>> design/raw10_unpack_to_raw16_stream.sv
// Top level of the raw10 unpack stream block: configuration registers,
// front part, work queue and back part. Depends on r10u_pkg and the r10u_* modules.
//
//   channel  ports                          accepted when
//   input    push, full, din                push && !full
//   result   empty, pop, dout               pop && !empty
//   config   cfg_write, cfg_index, cfg_data cfg_write
//
// An accepted passthrough byte passes the work queue and the back part's working entry
// before it can be popped; later ones follow one per cycle while pop is held high.
// In packed ten-bit mode five words enter at one per cycle while full is low; the
// back part sends the group as eight bytes, one per cycle while pop is held high.
// Reset is synchronous and clears the counters and configuration; no sweep follows.
// full rises while the work queue is full; a stalled result holds on dout.
module raw10_unpack_to_raw16_stream
  import r10u_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              din,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             dout,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MODE_W-1:0]    pixel_mode;
  logic [PAYLOAD_W-1:0] payload_bytes;
  logic                 accept;
  logic                 enq;
  entry_t               enq_entry;
  logic                 q_rd;
  entry_t               q_entry;
  logic                 q_valid;

  assign accept = push && !full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode    <= MODE_RAW8;
      payload_bytes <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PIXEL_MODE:    pixel_mode    <= cfg_data[MODE_W-1:0];
        REG_PAYLOAD_BYTES: payload_bytes <= cfg_data[PAYLOAD_W-1:0];
        default:           ;
      endcase
    end
  end

  r10u_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .din           (din),
    .pixel_mode    (pixel_mode),
    .payload_bytes (payload_bytes),
    .enq           (enq),
    .enq_entry     (enq_entry)
  );

  r10u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (enq),
    .wr_entry  (enq_entry),
    .rd        (q_rd),
    .rd_entry  (q_entry),
    .not_empty (q_valid),
    .is_full   (full)
  );

  r10u_back u_back (
    .clk           (clk),
    .rst           (rst),
    .payload_bytes (payload_bytes),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .dout          (dout)
  );

endmodule

>>> design/r10u_front.sv
// Front part: accepts input words, tracks frame and group state, and
// classifies each word. Depends on r10u_pkg.
module r10u_front
  import r10u_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  in_item_t             din,
  input  logic [MODE_W-1:0]    pixel_mode,
  input  logic [PAYLOAD_W-1:0] payload_bytes,
  output logic                 enq,
  output entry_t               enq_entry
);

  logic [31:0]       group_bytes;
  logic [31:0]       group_bytes_next;
  logic [2:0]        group_fill;
  logic [2:0]        group_fill_next;
  logic [SENT_W-1:0] bytes_sent;
  logic [SENT_W-1:0] bytes_sent_next;
  logic              limit_hit;
  logic [SENT_W-1:0] sent_plus1;

  assign limit_hit  = bytes_sent >= {1'b0, payload_bytes};
  assign sent_plus1 = bytes_sent + SENT_W'(1);

  // Classify the accepted word and update the frame counters.
  always_comb begin
    group_bytes_next = group_bytes;
    group_fill_next  = group_fill;
    bytes_sent_next  = bytes_sent;
    enq              = 1'b0;
    enq_entry.kind   = KIND_PASS;
    enq_entry.data   = {32'd0, din.data_byte};
    enq_entry.cnt    = sent_plus1;
    if (accept) begin
      if (din.action == ACT_START) begin
        group_fill_next = 3'd0;
        bytes_sent_next = '0;
      end else if (!limit_hit) begin
        if (pixel_mode != MODE_RAW10) begin
          enq             = 1'b1;
          bytes_sent_next = sent_plus1;
        end else if (group_fill < 3'd4) begin
          group_bytes_next = {group_bytes[23:0], din.data_byte};
          group_fill_next  = group_fill + 3'd1;
        end else begin
          enq             = 1'b1;
          enq_entry.kind  = KIND_GROUP;
          enq_entry.data  = {group_bytes, din.data_byte};
          group_fill_next = 3'd0;
          bytes_sent_next = bytes_sent + SENT_W'(8);
        end
      end
    end
  end

  // Group contents need no reset: the fill count decides what is valid.
  always_ff @(posedge clk) begin
    group_bytes <= group_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_fill <= 3'd0;
      bytes_sent <= '0;
    end else begin
      group_fill <= group_fill_next;
      bytes_sent <= bytes_sent_next;
    end
  end

endmodule

>>> design/r10u_queue.sv
// Short queue of work entries between the front and back parts.
// Depends on r10u_pkg for the entry type.
module r10u_queue
  import r10u_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_entry,
  input  logic   rd,
  output entry_t rd_entry,
  output logic   not_empty,
  output logic   is_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign not_empty = fill != '0;
  assign is_full   = fill == CNT_W'(DEPTH);
  assign rd_entry  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        fill <= fill + CNT_W'(1);
      end else if (rd && !wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

>>> design/r10u_back.sv
// Back part: takes work entries and sends one payload byte per cycle while pop is
// held high, unpacking ten-bit groups into sixteen-bit little-endian words.
// Depends on r10u_pkg.
module r10u_back
  import r10u_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PAYLOAD_W-1:0] payload_bytes,
  input  logic                 q_valid,
  input  entry_t               q_entry,
  output logic                 q_rd,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            dout
);

  logic               cur_valid;
  kind_t              cur_kind;
  logic [GROUP_W-1:0] cur_data;
  logic [SENT_W-1:0]  cnt;
  logic [2:0]         idx;
  logic               is_last;
  logic               take;
  logic               load;
  logic [9:0]         sample;

  assign is_last = (cur_kind == KIND_PASS) || (idx == 3'd7);
  assign take    = pop && cur_valid;
  assign load    = q_valid && (!cur_valid || (take && is_last));
  assign q_rd    = load;
  assign empty   = !cur_valid;

  // Pick the ten-bit sample for the current word, most significant first.
  always_comb begin
    case (idx[2:1])
      2'd0:    sample = cur_data[39:30];
      2'd1:    sample = cur_data[29:20];
      2'd2:    sample = cur_data[19:10];
      default: sample = cur_data[9:0];
    endcase
  end

  // Result word: a passthrough byte, or the sample shifted up by six, low byte first.
  always_comb begin
    if (cur_kind == KIND_PASS) begin
      dout.out_byte = cur_data[7:0];
    end else if (!idx[0]) begin
      dout.out_byte = {sample[1:0], 6'd0};
    end else begin
      dout.out_byte = sample[9:2];
    end
    dout.run_last     = is_last;
    dout.payload_done = cnt >= {1'b0, payload_bytes};
  end

  // Working entry and byte counters.
  always_ff @(posedge clk) begin
    if (load) begin
      cur_kind <= q_entry.kind;
      cur_data <= q_entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
      cnt       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= 3'd0;
      cnt       <= q_entry.cnt;
    end else if (take) begin
      if (is_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
        cnt <= cnt + SENT_W'(1);
      end
    end
  end

endmodule

>>> tb/sv/tb_raw10_unpack_to_raw16_stream.sv
// Self-checking testbench for raw10_unpack_to_raw16_stream: directed tests, then random frames.
// A local predictor of the unpacker builds the expected output bytes for each accepted word.
// Depends on r10u_pkg and the raw10_unpack_to_raw16_stream design.
`timescale 1ns / 1ps

module tb_raw10_unpack_to_raw16_stream;
  import r10u_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_WORDS = 410;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX = 33'd8589672450;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t din = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t dout;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_PIXEL_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Idle percentages of the sender and the receiver.
  int send_idle = 23;
  int recv_idle = 55;
  int errors = 0;

  // Predictor state: configuration, group buffer and frame byte count.
  logic [MODE_W-1:0] cur_mode = MODE_RAW8;
  logic [PAYLOAD_W-1:0] payload_lim = '0;
  logic [31:0] group_buf = '0;
  logic [2:0] group_cnt = '0;
  logic [SENT_W-1:0] frame_sent = '0;
  int live_words = 0;
  out_item_t expected_bytes[$];

  raw10_unpack_to_raw16_stream uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .din(din),
    .empty(empty),
    .pop(pop),
    .dout(dout),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run ends as a failure if it does not finish in time.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Queue one expected output byte and advance the frame count.
  function automatic void emit_byte(input logic [7:0] b, input logic last);
    out_item_t r;
    frame_sent = frame_sent + 1'b1;
    r.out_byte = b;
    r.run_last = last;
    r.payload_done = (frame_sent >= {1'b0, payload_lim});
    expected_bytes.push_back(r);
  endfunction

  // Work out the output bytes caused by one accepted word.
  function automatic void predict_word(input in_item_t w);
    logic [3:0][9:0] smp;
    logic [15:0] word16;
    if (w.action == ACT_START) begin
      group_buf = '0;
      group_cnt = '0;
      frame_sent = '0;
      return;
    end
    // Once the limit is reached, data words are dropped.
    if (frame_sent >= {1'b0, payload_lim}) return;
    if (cur_mode != MODE_RAW10) begin
      emit_byte(w.data_byte, 1'b1);
      return;
    end
    if (group_cnt < 3'd4) begin
      group_buf = {group_buf[23:0], w.data_byte};
      group_cnt = group_cnt + 1'b1;
      return;
    end
    // Fifth byte completes the group: four samples, MSB first.
    smp[0] = {group_buf[31:24], group_buf[23:22]};
    smp[1] = {group_buf[21:16], group_buf[15:12]};
    smp[2] = {group_buf[11:8], group_buf[7:2]};
    smp[3] = {group_buf[1:0], w.data_byte};
    group_buf = '0;
    group_cnt = '0;
    for (int i = 0; i < 4; i++) begin
      word16 = {smp[i], 6'b0};
      emit_byte(word16[7:0], 1'b0);
      emit_byte(word16[15:8], i == 3);
    end
  endfunction

  // The receiver stalls at random.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle);
  end

  // Compare each popped byte with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %02h", dout.out_byte);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (dout.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, dout.out_byte);
          errors++;
        end
        if (dout.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, dout.run_last);
          errors++;
        end
        if (dout.payload_done !== want.payload_done) begin
          $error("payload_done: expected %0b, got %0b", want.payload_done, dout.payload_done);
          errors++;
        end
      end
    end
  end

  // Send one word; push stays high afterwards so back-to-back words need no toggle.
  // full is sampled at the falling edge, where it already holds its value for the
  // next rising edge.
  task automatic push_word(input logic act, input logic [7:0] b);
    in_item_t w;
    logic stalled;
    w.action = act;
    w.data_byte = b;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    din <= w;
    do begin
      @(negedge clk);
      stalled = full;
      @(posedge clk);
    end while (stalled);
    live_words++;
    predict_word(w);
  endtask

  // Stop sending and wait until every expected byte has arrived and the block is idle.
  task automatic drain();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers, mode first; the block must be idle.
  task automatic write_cfg(input logic [MODE_W-1:0] m, input logic [PAYLOAD_W-1:0] lim);
    cfg_write <= 1'b1;
    cfg_index <= REG_PIXEL_MODE;
    cfg_data <= CFG_DATA_W'(m);
    @(posedge clk);
    cur_mode = m;
    cfg_index <= REG_PAYLOAD_BYTES;
    cfg_data <= lim;
    @(posedge clk);
    payload_lim = lim;
    cfg_write <= 1'b0;
  endtask

  // Eight-bit passthrough up to a small limit, then a dropped word.
  task automatic test_passthrough_limit();
    write_cfg(MODE_RAW8, 33'd3);
    push_word(ACT_START, 8'h00);
    push_word(ACT_DATA, 8'h00);
    push_word(ACT_DATA, 8'hFF);
    push_word(ACT_DATA, 8'h5A);
    push_word(ACT_DATA, 8'h33);
    drain();
  endtask

  // A zero limit drops every data word.
  task automatic test_zero_limit();
    write_cfg(MODE_RAW16, '0);
    push_word(ACT_START, 8'hFF);
    push_word(ACT_DATA, 8'h12);
    drain();
  endtask

  // Two ten-bit groups; the second one overshoots the limit and is still sent whole.
  task automatic test_group_overshoot();
    write_cfg(MODE_RAW10, 33'd10);
    push_word(ACT_START, 8'h00);
    repeat (5) push_word(ACT_DATA, 8'hFF);
    push_word(ACT_DATA, 8'hC3);
    push_word(ACT_DATA, 8'h3C);
    push_word(ACT_DATA, 8'hA5);
    push_word(ACT_DATA, 8'h5A);
    push_word(ACT_DATA, 8'h96);
    push_word(ACT_DATA, 8'h77);
    drain();
  endtask

  // A partial group survives a detour through the unused mode, then completes.
  task automatic test_mode_switch_resume();
    write_cfg(MODE_RAW10, PAYLOAD_MAX);
    push_word(ACT_DATA, 8'h81);
    push_word(ACT_DATA, 8'h42);
    drain();
    write_cfg(MODE_UNUSED, PAYLOAD_MAX);
    push_word(ACT_DATA, 8'h7E);
    drain();
    write_cfg(MODE_RAW10, PAYLOAD_MAX);
    push_word(ACT_DATA, 8'h24);
    push_word(ACT_DATA, 8'h18);
    push_word(ACT_DATA, 8'hE7);
    drain();
  endtask

  // Random frames: mostly started cleanly, with stray starts and continued frames mixed in.
  task automatic test_random_frames();
    int base;
    int done_words;
    int pick;
    logic [MODE_W-1:0] m;
    logic [PAYLOAD_W-1:0] lim;
    base = live_words;
    done_words = 0;
    while (done_words < RANDOM_WORDS) begin
      if (done_words < RANDOM_WORDS / 3) begin
        send_idle = 23;
        recv_idle = 55;
      end else if (done_words < 2 * RANDOM_WORDS / 3) begin
        send_idle = 55;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case ($urandom_range(9))
        0: m = MODE_RAW8;
        1: m = MODE_RAW16;
        2: m = MODE_UNUSED;
        default: m = MODE_RAW10;
      endcase
      pick = $urandom_range(9);
      if (pick == 0) begin
        lim = '0;
      end else if (pick == 1) begin
        lim = PAYLOAD_MAX;
      end else if (pick == 2) begin
        lim = {1'($urandom_range(1)), 32'($urandom())};
        if (lim > PAYLOAD_MAX) lim = PAYLOAD_MAX;
      end else begin
        lim = PAYLOAD_W'($urandom_range(4, 96));
      end
      write_cfg(m, lim);
      if ($urandom_range(4) != 0) push_word(ACT_START, 8'($urandom_range(255)));
      repeat ($urandom_range(8, 40)) begin
        if ($urandom_range(24) == 0) push_word(ACT_START, 8'($urandom_range(255)));
        else push_word(ACT_DATA, 8'($urandom_range(255)));
      end
      drain();
      done_words = live_words - base;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_passthrough_limit();
    test_zero_limit();
    test_group_overshoot();
    test_mode_switch_resume();
    test_random_frames();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/r10u_pkg.sv
design/r10u_front.sv
design/r10u_queue.sv
design/r10u_back.sv
design/raw10_unpack_to_raw16_stream.sv
tb/sv/tb_raw10_unpack_to_raw16_stream.sv
